>>> hw/rtl/lfr_pkg.sv
package lfr_pkg;

	localparam int LEN_W       = 4;
	localparam int BURST_MAX   = 8;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 64;

	// Register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES      = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_BYTES  = CFG_INDEX_W'(3);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        has_byte;
		logic        out_last;
		logic [31:0] match_count;
		logic        any_match;
		logic [31:0] first_match_offset;
	} out_item_t;

	typedef struct packed {
		logic [LEN_W-1:0] pattern_length;
		logic [63:0]      pattern_bytes;
		logic [LEN_W-1:0] replacement_length;
		logic [63:0]      replacement_bytes;
	} cfg_regs_t;

	// Result bytes caused by one input item, plus end-of-text statistics
	typedef struct packed {
		logic [BURST_MAX-1:0][7:0] bytes;
		logic [LEN_W-1:0]          count;
		logic                      has_byte;
		logic                      last;
		logic [31:0]               match_count;
		logic                      any_match;
		logic [31:0]               first_offset;
	} burst_t;

endpackage

>>> hw/rtl/lfr_cfg.sv
module lfr_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [lfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lfr_pkg::CFG_DATA_W-1:0]    cfg_data,
	output lfr_pkg::cfg_regs_t                regs
);

	lfr_pkg::cfg_regs_t regs_q;

	// Write the addressed register, drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				lfr_pkg::REG_PATTERN_LENGTH: begin
					regs_q.pattern_length <= cfg_data[lfr_pkg::LEN_W-1:0];
				end
				lfr_pkg::REG_PATTERN_BYTES: begin
					regs_q.pattern_bytes <= cfg_data;
				end
				lfr_pkg::REG_REPLACEMENT_LENGTH: begin
					regs_q.replacement_length <= cfg_data[lfr_pkg::LEN_W-1:0];
				end
				lfr_pkg::REG_REPLACEMENT_BYTES: begin
					regs_q.replacement_bytes <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign regs = regs_q;

endmodule

>>> hw/rtl/lfr_core.sv
module lfr_core #(
	parameter int MAX_PATTERN = 8,
	parameter int COUNT_BITS  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lfr_pkg::cfg_regs_t  regs,
	input  logic                fire,
	input  lfr_pkg::in_item_t   item,
	output lfr_pkg::burst_t     burst
);

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);
	localparam int WIDE_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

	// Text state
	logic                  active_q;
	lfr_pkg::cfg_regs_t    act_q;
	logic [7:0]            window_q [MAX_PATTERN];
	logic [FILL_W-1:0]     fill_q;
	logic [COUNT_BITS-1:0] matches_q;
	logic [31:0]           pos_q;
	logic                  found_q;
	logic [31:0]           first_q;

	// Next-state and result logic
	lfr_pkg::cfg_regs_t         src;
	logic [lfr_pkg::LEN_W-1:0]  plen;
	logic [lfr_pkg::LEN_W-1:0]  rlen;
	logic [7:0]                 wn [lfr_pkg::BURST_MAX+1];
	logic [FILL_W-1:0]          fill_push;
	logic                       decide;
	logic                       equal;
	logic                       hit;
	logic [7:0]                 window_n [MAX_PATTERN];
	logic [FILL_W-1:0]          fill_n;
	logic [lfr_pkg::LEN_W-1:0]  nbytes;
	logic [COUNT_BITS-1:0]      matches_n;
	logic                       found_n;
	logic [31:0]                first_n;
	logic [32:0]                pos_sum;
	logic [31:0]                pos_n;
	logic [WIDE_W-1:0]          matches_wide;

	always_comb begin
		// Use the latched settings during a text, fresh ones at its first byte
		src  = active_q ? act_q : regs;
		plen = (src.pattern_length > lfr_pkg::LEN_W'(MAX_PATTERN))
			? lfr_pkg::LEN_W'(MAX_PATTERN) : src.pattern_length;
		rlen = (src.replacement_length > lfr_pkg::LEN_W'(lfr_pkg::BURST_MAX))
			? lfr_pkg::LEN_W'(lfr_pkg::BURST_MAX) : src.replacement_length;

		// Window with the new byte appended
		fill_push = fill_q + FILL_W'(1);
		for (int i = 0; i <= lfr_pkg::BURST_MAX; i++) begin
			wn[i] = 8'h00;
		end
		for (int i = 0; i < MAX_PATTERN; i++) begin
			wn[i] = (fill_q == FILL_W'(i)) ? item.in_byte : window_q[i];
		end

		// Compare the full window with the pattern
		decide = (lfr_pkg::LEN_W'(fill_push) == plen);
		equal  = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (lfr_pkg::LEN_W'(i) < plen && wn[i] != src.pattern_bytes[8*i +: 8]) begin
				equal = 1'b0;
			end
		end
		hit = (plen != '0) && decide && equal;

		burst          = '0;
		burst.has_byte = 1'b1;
		burst.last     = item.in_last;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			window_n[i] = window_q[i];
		end
		fill_n = fill_q;
		nbytes = '0;

		if (plen == '0) begin
			// Pass straight through
			burst.bytes[0] = item.in_byte;
			nbytes         = lfr_pkg::LEN_W'(1);
		end else if (hit) begin
			// Replace the whole window
			for (int i = 0; i < lfr_pkg::BURST_MAX; i++) begin
				burst.bytes[i] = src.replacement_bytes[8*i +: 8];
			end
			nbytes = rlen;
			fill_n = '0;
		end else if (decide && !item.in_last) begin
			// Release the oldest byte and advance the window
			burst.bytes[0] = wn[0];
			nbytes         = lfr_pkg::LEN_W'(1);
			for (int i = 0; i < MAX_PATTERN; i++) begin
				window_n[i] = wn[i+1];
			end
		end else if (item.in_last) begin
			// Flush everything the window holds
			for (int i = 0; i < lfr_pkg::BURST_MAX; i++) begin
				burst.bytes[i] = wn[i];
			end
			nbytes = lfr_pkg::LEN_W'(fill_push);
		end else begin
			// Hold the byte until the window is full
			for (int i = 0; i < MAX_PATTERN; i++) begin
				window_n[i] = wn[i];
			end
			fill_n = fill_push;
		end

		if (item.in_last) begin
			fill_n = '0;
		end

		// Statistics
		matches_n = matches_q;
		found_n   = found_q;
		first_n   = first_q;
		if (hit) begin
			if (matches_q != '1) begin
				matches_n = matches_q + COUNT_BITS'(1);
			end
			if (!found_q) begin
				found_n = 1'b1;
				first_n = pos_q;
			end
		end
		pos_sum = {1'b0, pos_q} + 33'(nbytes);
		pos_n   = pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];

		matches_wide = WIDE_W'(matches_n);

		// Bare end marker when the last item releases nothing; it carries no byte
		burst.count = nbytes;
		if (item.in_last && nbytes == '0) begin
			burst.count    = lfr_pkg::LEN_W'(1);
			burst.has_byte = 1'b0;
			burst.bytes    = '0;
		end

		if (item.in_last) begin
			burst.match_count  = (matches_wide > WIDE_W'(32'hFFFF_FFFF))
				? 32'hFFFF_FFFF : matches_wide[31:0];
			burst.any_match    = found_n;
			burst.first_offset = found_n ? first_n : 32'h0;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			fill_q    <= '0;
			matches_q <= '0;
			pos_q     <= '0;
			found_q   <= 1'b0;
			first_q   <= '0;
		end else if (fire) begin
			fill_q <= fill_n;
			if (item.in_last) begin
				active_q  <= 1'b0;
				matches_q <= '0;
				pos_q     <= '0;
				found_q   <= 1'b0;
				first_q   <= '0;
			end else begin
				active_q  <= 1'b1;
				matches_q <= matches_n;
				pos_q     <= pos_n;
				found_q   <= found_n;
				first_q   <= first_n;
			end
		end
	end

	// Latched settings and window bytes
	always_ff @(posedge clk) begin
		if (fire) begin
			if (!active_q) begin
				act_q <= regs;
			end
			for (int i = 0; i < MAX_PATTERN; i++) begin
				window_q[i] <= window_n[i];
			end
		end
	end

endmodule

>>> hw/rtl/lfr_emit.sv
module lfr_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  lfr_pkg::burst_t     burst,
	output logic                can_load,
	output logic                out_valid,
	input  logic                out_ready,
	output lfr_pkg::out_item_t  out_data
);

	logic [lfr_pkg::BURST_MAX-1:0][7:0] bytes_q;
	logic [lfr_pkg::LEN_W-1:0]          left_q;
	logic                               has_q;
	logic                               last_q;
	logic [31:0]                        count_q;
	logic                               any_q;
	logic [31:0]                        offset_q;
	logic                               final_item;
	logic                               take;

	assign out_valid  = (left_q != '0);
	assign take       = out_valid && out_ready;
	assign can_load   = (left_q == '0) || (left_q == lfr_pkg::LEN_W'(1) && out_ready);
	assign final_item = last_q && (left_q == lfr_pkg::LEN_W'(1));

	// Present the front byte; statistics ride on the final item only
	always_comb begin
		out_data                    = '0;
		out_data.out_byte           = bytes_q[0];
		out_data.has_byte           = has_q;
		out_data.out_last           = final_item;
		if (final_item) begin
			out_data.match_count        = count_q;
			out_data.any_match          = any_q;
			out_data.first_match_offset = offset_q;
		end
	end

	// Remaining item count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (load) begin
			left_q <= burst.count;
		end else if (take) begin
			left_q <= left_q - lfr_pkg::LEN_W'(1);
		end
	end

	// Load a new burst or shift out the item just taken
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q  <= burst.bytes;
			has_q    <= burst.has_byte;
			last_q   <= burst.last;
			count_q  <= burst.match_count;
			any_q    <= burst.any_match;
			offset_q <= burst.first_offset;
		end else if (take) begin
			for (int i = 0; i < lfr_pkg::BURST_MAX - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
			end
			bytes_q[lfr_pkg::BURST_MAX-1] <= 8'h00;
		end
	end

endmodule

>>> hw/rtl/literal_find_and_replace_stream.sv
// Channel  Handshake               Payload
// in       in_valid / in_ready     in_data   (in_byte, in_last)
// out      out_valid / out_ready   out_data  (byte, flags, statistics on the last item)
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// One input item is decided in the cycle it is accepted and its result items are
// loaded into an output register; items that cause at most one result flow at one
// per cycle while out_ready is high. An R-byte replacement or an N-byte end-of-text
// flush holds the input while the output register drains one per cycle to its last item.
// Reset clears window fill, counters and output state; settings reset to zero.
// The output register stalls on out_ready; the input stalls only behind it.
module literal_find_and_replace_stream #(
	parameter int MAX_PATTERN = 8,
	parameter int COUNT_BITS  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  lfr_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output lfr_pkg::out_item_t                out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lfr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	lfr_pkg::cfg_regs_t regs;
	lfr_pkg::burst_t    burst;
	logic               fire;

	assign cfg_ready = 1'b1;
	assign fire      = in_valid && in_ready;

	lfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	lfr_core #(
		.MAX_PATTERN (MAX_PATTERN),
		.COUNT_BITS  (COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.fire   (fire),
		.item   (in_data),
		.burst  (burst)
	);

	lfr_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.burst     (burst),
		.can_load  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int MAX_PATTERN  = 8;
	localparam int MAX_REPL     = 8;
	localparam int COUNT_BITS   = 32;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int REPORT_LINES = 40;
	// Index past the register file; writes to it must be dropped
	localparam logic [lfr_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = '1;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	lfr_pkg::in_item_t               in_data;
	logic                            out_valid;
	logic                            out_ready;
	lfr_pkg::out_item_t              out_data;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [lfr_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [lfr_pkg::CFG_DATA_W-1:0]  cfg_data;

	bit          idle_on;
	int unsigned cycles, mismatches, items_sent, results_seen, texts_done, texts_matched;

	// Model of the editor: settings, latched copy, lookahead window, statistics
	lfr_pkg::cfg_regs_t regs, held;
	bit                 in_text;
	logic [7:0]         window_bytes [MAX_PATTERN];
	int unsigned        window_fill, pat_len, rep_len;
	logic [31:0]        replace_count, out_pos, first_pos;
	bit                 first_hit;
	lfr_pkg::out_item_t step_edits[$];
	lfr_pkg::out_item_t edited_text_q[$];

	literal_find_and_replace_stream #(
		.MAX_PATTERN(MAX_PATTERN),
		.COUNT_BITS (COUNT_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Append one edited byte and advance the output position
	function automatic void put_edited_byte(input logic [7:0] b);
		lfr_pkg::out_item_t r;
		r = '0;
		r.out_byte = b;
		r.has_byte = 1'b1;
		step_edits.push_back(r);
		if (out_pos != '1)
			out_pos++;
	endfunction

	function automatic void release_oldest_byte();
		put_edited_byte(window_bytes[0]);
		for (int i = 0; i < MAX_PATTERN - 1; i++)
			window_bytes[i] = window_bytes[i + 1];
		window_fill--;
	endfunction

	// Work out the edited bytes caused by one accepted text byte
	function automatic void edit_byte(input lfr_pkg::in_item_t it);
		lfr_pkg::out_item_t tail;
		lfr_pkg::out_item_t bare;
		bit                 hit;
		bare = '0;
		if (!in_text) begin
			held    = regs;
			pat_len = (regs.pattern_length > MAX_PATTERN) ? MAX_PATTERN : regs.pattern_length;
			rep_len = (regs.replacement_length > MAX_REPL) ? MAX_REPL : regs.replacement_length;
			in_text = 1'b1;
		end
		step_edits.delete();
		if (pat_len == 0) begin
			put_edited_byte(it.in_byte);
		end else begin
			if (window_fill < MAX_PATTERN) begin
				window_bytes[window_fill] = it.in_byte;
				window_fill++;
			end
			if (window_fill >= pat_len) begin
				hit = 1'b1;
				for (int i = 0; i < pat_len; i++)
					if (window_bytes[i] !== held.pattern_bytes[8*i +: 8])
						hit = 1'b0;
				if (hit) begin
					if (!first_hit) begin
						first_hit = 1'b1;
						first_pos = out_pos;
					end
					if (replace_count != '1)
						replace_count++;
					for (int i = 0; i < rep_len; i++)
						put_edited_byte(held.replacement_bytes[8*i +: 8]);
					window_fill = 0;
				end else begin
					release_oldest_byte();
				end
			end
		end
		// Flush the window and attach the statistics to the final result
		if (it.in_last) begin
			while (window_fill > 0)
				release_oldest_byte();
			if (step_edits.size() == 0)
				step_edits.push_back(bare);
			tail = step_edits.pop_back();
			tail.out_last           = 1'b1;
			tail.match_count        = replace_count;
			tail.any_match          = first_hit;
			tail.first_match_offset = first_hit ? first_pos : '0;
			step_edits.push_back(tail);
			texts_done++;
			if (first_hit)
				texts_matched++;
			replace_count = '0;
			out_pos       = '0;
			first_hit     = 1'b0;
			first_pos     = '0;
			in_text       = 1'b0;
		end
		foreach (step_edits[i])
			edited_text_q.push_back(step_edits[i]);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatches < REPORT_LINES)
			$display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
				cycles, what, got, want);
		mismatches++;
	endtask

	// Send one text byte; valid stays high afterwards until the next item or a drain
	task automatic send_item(input logic [7:0] b, input logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_data.in_byte = b;
		in_data.in_last = last;
		in_valid        = 1'b1;
		do @(posedge clk); while (!in_ready);
		edit_byte(in_data);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input logic [7:0] text [$]);
		foreach (text[i])
			send_item(text[i], i == text.size() - 1);
	endtask

	// Drop valid, wait for every pending edit, then let the block settle
	task automatic drain_results();
		in_valid = 1'b0;
		while (edited_text_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// One register write; caller lowers cfg_valid after the last of a group
	task automatic write_reg(input logic [lfr_pkg::CFG_INDEX_W-1:0] idx,
		input logic [lfr_pkg::CFG_DATA_W-1:0] d);
		cfg_index = idx;
		cfg_data  = d;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			lfr_pkg::REG_PATTERN_LENGTH:
				regs.pattern_length = d[lfr_pkg::LEN_W-1:0];
			lfr_pkg::REG_PATTERN_BYTES:
				regs.pattern_bytes = d;
			lfr_pkg::REG_REPLACEMENT_LENGTH:
				regs.replacement_length = d[lfr_pkg::LEN_W-1:0];
			lfr_pkg::REG_REPLACEMENT_BYTES:
				regs.replacement_bytes = d;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(input logic [63:0] plen_word, input logic [63:0] pat,
		input logic [63:0] rlen_word, input logic [63:0] rep);
		drain_results();
		write_reg(lfr_pkg::REG_PATTERN_LENGTH, plen_word);
		write_reg(lfr_pkg::REG_PATTERN_BYTES, pat);
		write_reg(lfr_pkg::REG_REPLACEMENT_LENGTH, rlen_word);
		write_reg(lfr_pkg::REG_REPLACEMENT_BYTES, rep);
		cfg_valid = 1'b0;
	endtask

	// Empty pattern: bytes at both extremes pass straight through
	task automatic test_pass_through();
		set_config(64'd0, {$urandom, $urandom}, 64'd3, {$urandom, $urandom});
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(8'h5A, 1'b1);
	endtask

	// Text shorter than the pattern is flushed on the last byte
	task automatic test_short_text();
		set_config(64'd4, 64'h44434241, 64'd2, 64'h7A79);
		send_item(8'h41, 1'b0);
		send_item(8'h42, 1'b1);
	endtask

	// Empty replacement deletes the match, leaving a bare end marker
	task automatic test_delete_and_bare_end();
		set_config(64'd3, 64'h7A7978, 64'd0, '1);
		send_item(8'h78, 1'b0);
		send_item(8'h79, 1'b0);
		send_item(8'h7A, 1'b1);
		send_item(8'h71, 1'b0);
		send_item(8'h78, 1'b0);
		send_item(8'h79, 1'b0);
		send_item(8'h7A, 1'b1);
	endtask

	// Length registers of fifteen are taken as the full eight bytes
	task automatic test_clamped_lengths();
		set_config('1, 64'h0807060504030201, '1, 64'h8877665544332211);
		for (int i = 1; i <= MAX_PATTERN + 1; i++)
			send_item(8'(i), i == MAX_PATTERN + 1);
	endtask

	// Matches do not overlap: scanning resumes behind each match
	task automatic test_resume_after_match();
		set_config(64'd2, 64'h6161, 64'd1, 64'h62);
		send_item(8'h61, 1'b0);
		send_item(8'h61, 1'b0);
		send_item(8'h61, 1'b1);
	endtask

	// Writes to unmapped indexes leave the settings alone
	task automatic test_ignored_index();
		set_config(64'd2, 64'h4241, 64'd1, 64'h5A);
		drain_results();
		write_reg(REG_UNMAPPED, '1);
		write_reg(lfr_pkg::CFG_INDEX_W'($urandom_range(4, 254)), {$urandom, $urandom});
		cfg_valid = 1'b0;
		send_item(8'h41, 1'b0);
		send_item(8'h42, 1'b1);
	endtask

	// Random settings and texts built mostly from pattern copies and a small alphabet
	task automatic test_random_texts(input int unsigned n_items);
		int unsigned target, eff, text_len, pick, cut, plen_raw, rlen_raw;
		logic [7:0]  sym [3];
		logic [63:0] pat, plen_word, rlen_word;
		logic [7:0]  text [$];
		bit          fresh;
		target = items_sent + n_items;
		fresh  = 1'b1;
		eff    = 0;
		pat    = '0;
		while (items_sent < target) begin
			if (fresh || $urandom_range(0, 2) == 0) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					plen_raw = 0;
				else if (pick == 1)
					plen_raw = $urandom_range(9, 15);
				else if (pick < 4)
					plen_raw = MAX_PATTERN;
				else
					plen_raw = $urandom_range(1, 4);
				rlen_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
					: $urandom_range(0, MAX_REPL);
				eff = (plen_raw > MAX_PATTERN) ? MAX_PATTERN : plen_raw;
				foreach (sym[i])
					sym[i] = 8'($urandom_range(0, 255));
				pat = {$urandom, $urandom};
				for (int i = 0; i < eff; i++)
					pat[8*i +: 8] = sym[$urandom_range(0, 2)];
				plen_word      = {$urandom, $urandom};
				plen_word[3:0] = 4'(plen_raw);
				rlen_word      = {$urandom, $urandom};
				rlen_word[3:0] = 4'(rlen_raw);
				set_config(plen_word, pat, rlen_word, {$urandom, $urandom});
				fresh = 1'b0;
			end
			// Build the text: whole copies, broken prefixes, alphabet and stray bytes
			text.delete();
			text_len = $urandom_range(1, 20);
			while (text.size() < text_len) begin
				pick = $urandom_range(0, 9);
				if (pick < 4 && eff > 0) begin
					cut = (pick == 0) ? $urandom_range(1, eff) : eff;
					for (int i = 0; i < cut; i++)
						text.push_back(pat[8*i +: 8]);
				end else if (pick == 9) begin
					text.push_back(8'($urandom_range(0, 255)));
				end else begin
					text.push_back(sym[$urandom_range(0, 2)]);
				end
			end
			send_text(text);
		end
	endtask

	// Receiver: ready with random stall bursts
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	// Compare each edited byte with the oldest expectation
	always @(posedge clk) begin : check_edits
		lfr_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (edited_text_q.size() == 0) begin
				report_mismatch("result with nothing pending", 64'(out_data.out_byte), 64'(0));
			end else begin
				want = edited_text_q.pop_front();
				if (out_data.out_byte !== want.out_byte)
					report_mismatch("out_byte", 64'(out_data.out_byte), 64'(want.out_byte));
				if (out_data.has_byte !== want.has_byte)
					report_mismatch("has_byte", 64'(out_data.has_byte), 64'(want.has_byte));
				if (out_data.out_last !== want.out_last)
					report_mismatch("out_last", 64'(out_data.out_last), 64'(want.out_last));
				if (out_data.match_count !== want.match_count)
					report_mismatch("match_count", 64'(out_data.match_count),
						64'(want.match_count));
				if (out_data.any_match !== want.any_match)
					report_mismatch("any_match", 64'(out_data.any_match), 64'(want.any_match));
				if (out_data.first_match_offset !== want.first_match_offset)
					report_mismatch("first_match_offset", 64'(out_data.first_match_offset),
						64'(want.first_match_offset));
			end
		end
	end

	// Hold the run to a cycle budget
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("cycle limit hit with %0d results pending", edited_text_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		idle_on       = 1'b1;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		arst_n        = 1'b0;
		regs          = '0;
		held          = '0;
		in_text       = 1'b0;
		window_fill   = 0;
		replace_count = '0;
		out_pos       = '0;
		first_hit     = 1'b0;
		first_pos     = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_pass_through();
		test_short_text();
		test_delete_and_bare_end();
		test_clamped_lengths();
		test_resume_after_match();
		test_ignored_index();
		test_random_texts(130);
		idle_on = 1'b0;
		test_random_texts(60);
		drain_results();

		$display("Covered %0d texts (%0d with a replacement), %0d text bytes, %0d results checked,",
			texts_done, texts_matched, items_sent, results_seen);
		$display("over settings from pass-through and deletion to full-length pattern and replacement.");
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
